[rtl/spq_pkg.sv]
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/spq_cell.sv]
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
`default_nettype none
module spq_cell (
  input  wire                              clk,
  input  wire spq_pkg::cell_ctrl_t         ctrl,
  input  wire                              valid,
  input  wire                              prev_ge,
  input  wire  signed [spq_pkg::DATA_W-1:0] prev_entry,
  input  wire  signed [spq_pkg::DATA_W-1:0] next_entry,
  output logic                             ge,
  output logic signed [spq_pkg::DATA_W-1:0] entry
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] entry_next;

  assign ge = valid && !(entry < ctrl.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          entry_next = ctrl.value;
        end else begin
          entry_next = prev_entry;
        end
      end
    end else if (ctrl.rem) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: cell chain, entry count and output register.
// Each input transfer's result is registered and appears on the master side in the next cycle.
// Throughput: one item per cycle if not stalled; every cell compares and shifts in the same cycle.
// The output register frees s_tready whenever the result is empty or being taken.
// Reset: synchronous, active high; clears the entry count and the output valid.
// Cell contents are not cleared; only cells below the entry count are read.
`default_nettype none
module sorted_priority_queue (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [spq_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] value
  input  wire                                s_tuser,  // [0] command
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [31:0] removed_value, [36:32] entry_count
  output logic [spq_pkg::STAT_W-1:0]         m_tuser   // [1:0] status
);
  import spq_pkg::*;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     take;
  logic                     is_full;
  logic                     is_empty;
  cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]         valid;
  logic [DEPTH-1:0]         ge;
  logic signed [DATA_W-1:0] entry [DEPTH];
  logic signed [DATA_W-1:0] removed_value;
  logic [OUT_CNT_W-1:0]     entry_count;
  status_t                  status;
  status_t                  status_next;
  logic signed [DATA_W-1:0] removed_next;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    ctrl.ins     = take && (command_t'(s_tuser) == CMD_INSERT) && !is_full;
    ctrl.rem     = take && (command_t'(s_tuser) == CMD_REMOVE) && !is_empty;
    ctrl.value   = $signed(s_tdata[DATA_W-1:0]);
    count_next   = count;
    status_next  = STATUS_OK;
    removed_next = '0;
    if (command_t'(s_tuser) == CMD_INSERT) begin
      if (is_full) begin
        status_next = STATUS_OVERFLOW;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = STATUS_UNDERFLOW;
      end else begin
        count_next   = count - CNT_W'(1);
        removed_next = entry[0];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      if (DEPTH > 1) begin : g_multi
        spq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .valid      (valid[i]),
          .prev_ge    (1'b1),
          .prev_entry (entry[i]),
          .next_entry (entry[i+1]),
          .ge         (ge[i]),
          .entry      (entry[i])
        );
      end else begin : g_single
        spq_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .valid      (valid[i]),
          .prev_ge    (1'b1),
          .prev_entry (entry[i]),
          .next_entry (entry[i]),
          .ge         (ge[i]),
          .entry      (entry[i])
        );
      end
    end else if (i == DEPTH - 1) begin : g_last
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid      (valid[i]),
        .prev_ge    (ge[i-1]),
        .prev_entry (entry[i-1]),
        .next_entry (entry[i]),
        .ge         (ge[i]),
        .entry      (entry[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid      (valid[i]),
        .prev_ge    (ge[i-1]),
        .prev_entry (entry[i-1]),
        .next_entry (entry[i+1]),
        .ge         (ge[i]),
        .entry      (entry[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      removed_value <= removed_next;
      status        <= status_next;
      entry_count   <= OUT_CNT_W'(count_next);
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - DATA_W - OUT_CNT_W){1'b0}}, entry_count, removed_value};
  assign m_tuser = status;

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the sorted priority queue: directed and random insert/remove traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import spq_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [DATA_W-1:0]    removed_value;
    status_t              status;
    logic [OUT_CNT_W-1:0] entry_count;
  } queue_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]      m_tuser;

  logic signed [DATA_W-1:0] held_values[$];
  queue_result_t            pending_results[$];
  int                       mismatches;
  int                       idle_cycles;
  bit                       no_gaps;

  sorted_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2, 3: return DATA_W'($signed($urandom_range(0, 7)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic queue_result_t predict_queue(command_t cmd, logic signed [DATA_W-1:0] v);
    queue_result_t res;
    int pos;
    res.removed_value = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (held_values.size() >= DEPTH) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held_values.size() && !(held_values[pos] < v)) pos++;
        held_values.insert(pos, v);
      end
    end else begin
      if (held_values.size() == 0) begin
        res.status = STATUS_UNDERFLOW;
      end else begin
        res.removed_value = held_values.pop_front();
      end
    end
    res.entry_count = OUT_CNT_W'(held_values.size());
    return res;
  endfunction

  // Enter and leave at a falling edge.
  task automatic send_item(command_t cmd, logic [DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tuser  = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tuser  = cmd;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_queue(cmd, v));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected %h, got %h", field, want, got);
    end
  endtask

  task automatic test_underflow_and_overflow();
    logic [DATA_W-1:0] fill[16];
    fill = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
             32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hffff_fffb,
             32'h0000_0005, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555,
             32'haaaa_aaaa, 32'h0000_0005, 32'h0000_0000, 32'h1234_5678};
    send_item(CMD_REMOVE, 32'hffff_ffff);
    send_item(CMD_REMOVE, 32'h0000_0000);
    foreach (fill[i]) send_item(CMD_INSERT, fill[i]);
    send_item(CMD_INSERT, 32'h7fff_ffff);
    send_item(CMD_INSERT, 32'h8000_0000);
    repeat (3) send_item(CMD_REMOVE, $urandom);
  endtask

  task automatic test_random_traffic(int count);
    int insert_pct;
    int i;
    insert_pct = 50;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        send_item(CMD_INSERT, pick_value());
      end else begin
        send_item(CMD_REMOVE, $urandom);
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    int i;
    no_gaps = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i < count / 2) begin
        send_item(($urandom_range(0, 3) == 0) ? CMD_REMOVE : CMD_INSERT, pick_value());
      end else begin
        send_item(($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_REMOVE, pick_value());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (pick_gap() > 0) begin
        m_tready = 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, m_tdata[DATA_W-1:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.removed_value) begin
          flag_mismatch("removed_value", want.removed_value, m_tdata[31:0]);
        end
        if (m_tuser !== want.status) begin
          flag_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser));
        end
        if (m_tdata[36:32] !== want.entry_count) begin
          flag_mismatch("entry_count", DATA_W'(want.entry_count), DATA_W'(m_tdata[36:32]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    no_gaps     = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_underflow_and_overflow();
    wait_drained();
    test_random_traffic(200);
    test_back_to_back(48);
    wait_drained();
    test_random_traffic(180);

    wait_drained();
    repeat (8) @(negedge clk);
    if (pending_results.size() > 0) begin
      $display("%0d results never arrived", pending_results.size());
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sorted_priority_queue.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
sim/tb.sv
